// ===== hw/rtl/sha_pkg.sv =====
// ============================================================================
// SHA-256 package
// Shared types, constants and the rotate function for the digest block.
// ============================================================================
`default_nettype none

package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int LengthPos  = 56;
    localparam logic [7:0] PadMark = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic       store_byte;   // write in byte at fill position
        logic       store_pad;    // write padding byte at fill position
        logic       pad_mark;     // padding byte is the 0x80 mark
        logic       pad_length;   // length field lands in this block
        logic       load;         // start compression (copy hash to working vars)
        logic       round;        // one round
        logic       update;       // add working vars into hash
        logic       clear;        // return to initial vector
        logic       count_byte;   // bump byte total
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } dp_status_t;

    localparam logic [31:0] InitVector [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha_if.sv =====
// ============================================================================
// SHA-256 channel interfaces
// Valid/ready channels for message bytes in and digest words out.
// ============================================================================
`default_nettype none

interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (output valid, digest_word, word_number, final_word, input ready);
    modport sink   (input valid, digest_word, word_number, final_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sha_datapath.sv =====
// ============================================================================
// SHA-256 datapath
// Block store, schedule, working variables, hash words and byte total.
// ============================================================================
`default_nettype none

module sha_datapath
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic [2:0]  out_sel,
    output dp_status_t       status,
    output logic [31:0]      hash_out
);

    logic [5:0]  fill_reg, fill_next;
    logic [60:0] total_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  rnd_reg;

    logic [7:0]  wr_byte;
    logic [63:0] bit_len;
    logic [31:0] w_new, w_use, t1, t2, e, a, s0, s1;
    logic [2:0]  len_idx;
    logic [3:0]  word_idx;
    logic [1:0]  lane_idx;

    assign bit_len  = {total_reg, 3'b000};
    assign len_idx  = fill_reg[2:0];
    assign word_idx = fill_reg[5:2];
    assign lane_idx = fill_reg[1:0];

    always_comb
    begin
        if (cmd.store_byte)
            wr_byte = in_byte;
        else if (cmd.pad_mark)
            wr_byte = PadMark;
        else if (cmd.pad_length && fill_reg >= 6'(LengthPos))
            wr_byte = bit_len[8*(7 - len_idx) +: 8];
        else
            wr_byte = 8'h00;
    end

    assign fill_next = fill_reg + 6'd1;

    // schedule: window w_reg[0] is word r
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign w_use = w_reg[0];

    assign e  = v_reg[4];
    assign a  = v_reg[0];
    assign t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & v_reg[5]) ^ (~e & v_reg[6])) + RoundConst[rnd_reg] + w_use;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // block bytes are collected straight into the schedule window, big-endian
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte || cmd.store_pad)
            w_reg[word_idx][8*(3 - lane_idx) +: 8] <= wr_byte;
        else if (cmd.round)
        begin
            // word r+16 depends on r, r+1, r+9, r+14
            for (int k = 0; k < 15; k++)
                w_reg[k] <= w_reg[k+1];
            w_reg[15] <= (rnd_reg < 6'd48) ? w_new : w_reg[15];
        end
    end

    // working variables hold payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 8; k++)
                v_reg[k] <= hash_reg[k];
        end
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= e;
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= a;
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            for (int k = 0; k < 8; k++)
                hash_reg[k] <= InitVector[k];
        end
        else
        begin
            if (cmd.store_byte || cmd.store_pad)
                fill_reg <= fill_next;
            if (cmd.count_byte)
                total_reg <= total_reg + 61'd1;
            if (cmd.load)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.update)
                for (int k = 0; k < 8; k++)
                    hash_reg[k] <= hash_reg[k] + v_reg[k];
            if (cmd.clear)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
                for (int k = 0; k < 8; k++)
                    hash_reg[k] <= InitVector[k];
            end
        end
    end

    assign status.fill       = fill_reg;
    assign status.round_last = (rnd_reg == 6'd63);
    assign hash_out          = hash_reg[out_sel];

endmodule

`default_nettype wire

// ===== hw/rtl/sha_ctrl.sv =====
// ============================================================================
// SHA-256 controller
// Sequences byte intake, compression, padding and digest output.
// ============================================================================
`default_nettype none

module sha_ctrl
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_present,
    input  wire logic       in_end,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      out_sel,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        ending_reg, ending_next;  // message end seen
    logic [2:0]  word_reg, word_next;
    logic        in_fire, out_fire;
    logic        pad_active, extra_block, digest_done;
    logic        pad_mark, pad_length, last_block;

    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;
    assign out_sel     = word_reg;
    assign pad_active  = (state_reg == ST_PAD);
    assign extra_block = (state_reg == ST_UPDATE) && ending_reg && !last_block;
    assign digest_done = (state_reg == ST_EMIT) && out_fire && (word_reg == 3'd7);

    sha_pad_ctrl u_pad (
        .clk         (clk),
        .rst_n       (rst_n),
        .pad_active  (pad_active),
        .extra_block (extra_block),
        .digest_done (digest_done),
        .fill        (status.fill),
        .pad_mark    (pad_mark),
        .pad_length  (pad_length),
        .last_block  (last_block)
    );

    always_comb
    begin
        state_next  = state_reg;
        ending_next = ending_reg;
        word_next   = word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ending_next = in_end;
                    if (in_present && status.fill == 6'd63)
                        state_next = ST_LOAD;
                    else if (in_end)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:    if (status.fill == 6'd63) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_ROUND;
            ST_ROUND:  if (status.round_last) state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!ending_reg)
                    state_next = ST_IDLE;
                else if (last_block)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;   // extra block for the length
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    word_next = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        state_next  = ST_IDLE;
                        ending_next = 1'b0;
                    end
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.store_byte = in_fire && in_present;
                cmd.count_byte = in_fire && in_present;
            end
            ST_PAD:
            begin
                cmd.store_pad  = 1'b1;
                cmd.pad_mark   = pad_mark;
                cmd.pad_length = pad_length;
            end
            ST_LOAD:   cmd.load = 1'b1;
            ST_ROUND:  cmd.round = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.clear = digest_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ending_reg <= 1'b0;
            word_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ending_reg <= ending_next;
            word_reg   <= word_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_message_digest.sv =====
// ============================================================================
// SHA-256 message digest
// At most one message byte per input item; eight digest words per message.
// ============================================================================
// Usage:
//   in  : valid/ready channel of data_byte, byte_present, end_of_message.
//   out : valid/ready channel of digest_word, word_number, final_word.
//   Every 64th byte starts a compression (load, 64 rounds at one round per
//   cycle, hash update), during which in.ready is low. On end_of_message
//   the block is padded one byte per cycle up to the block end, compressed,
//   and a second padded block follows when fewer than 9 bytes were free.
//   in.ready stays low meanwhile. An end byte that completes a block has
//   that block compressed before padding begins. The eight words then
//   leave one per cycle while out.ready is high; a stall simply holds the
//   current word. No new byte is taken until the last word has gone.
//   Reset clears the fill count and byte total and loads the initial hash.
//   The block store needs no clearing pass.
// ============================================================================
`default_nettype none

module sha256_message_digest
    import sha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] sel;
    logic [31:0] hash;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_present (in_ch.byte_present),
        .in_end     (in_ch.end_of_message),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_sel    (sel),
        .status     (status),
        .cmd        (cmd)
    );

    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_byte  (in_ch.data_byte),
        .out_sel  (sel),
        .status   (status),
        .hash_out (hash)
    );

    assign out_ch.digest_word = hash;
    assign out_ch.word_number = sel;
    assign out_ch.final_word  = (sel == 3'd7);

endmodule

`default_nettype wire

// ===== hw/rtl/sha_pad_ctrl.sv =====
// ============================================================================
// SHA-256 padding controller
// Tracks where the pad mark and the length field land across padded blocks.
// ============================================================================
`default_nettype none

module sha_pad_ctrl
    import sha_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pad_active,   // controller writing pad bytes
    input  wire logic       extra_block,  // length moves to a further block
    input  wire logic       digest_done,  // last digest word taken
    input  wire logic [5:0] fill,
    output logic            pad_mark,
    output logic            pad_length,
    output logic            last_block
);

    logic mark_reg, mark_next;   // pad mark written
    logic last_reg, last_next;   // current padded block holds the length

    assign pad_mark   = pad_active && !mark_reg;
    assign pad_length = pad_active && last_reg;
    assign last_block = last_reg;

    always_comb
    begin
        mark_next = mark_reg;
        last_next = last_reg;
        if (digest_done)
        begin
            mark_next = 1'b0;
            last_next = 1'b0;
        end
        else if (pad_mark)
        begin
            // length fits if the mark lands below it
            mark_next = 1'b1;
            last_next = (fill < 6'(LengthPos));
        end
        else if (extra_block)
            last_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
            last_reg <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sha_checker.sv =====
// ============================================================================
// SHA-256 port checker
// Watches the top-level channels over time.
// ============================================================================
`default_nettype none

module sha_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_number,
    input wire logic        final_word
);

    // no byte is taken while a digest is pending
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input accepted during digest output");

    assert property (@(posedge clk) disable iff (!rst_n) final_word == (word_number == 3'd7))
        else $error("final_word mismatch");

    // words advance in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_word |=> out_valid && word_number == $past(word_number) + 3'd1)
        else $error("digest words out of order");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_number))
        else $error("stalled word changed");

endmodule

bind sha256_message_digest sha_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .digest_word (out_ch.digest_word),
    .word_number (out_ch.word_number),
    .final_word  (out_ch.final_word)
);

`default_nettype wire

// ===== bench/tb.sv =====
// ============================================================================
// SHA-256 digest testbench
// Streams byte messages through the digest block under random stalls on both
// channels and checks every digest word against an in-bench SHA-256 model.
// ============================================================================
`default_nettype none

module tb
    import sha_pkg::*;
();

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        final_word;
    } digest_res_t;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_message_digest dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // model state
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [31:0] hv [8];
    logic [60:0] total;

    msg_item_t   pending_items [$];
    digest_res_t digest_queue [$];

    int  mismatches = 0;
    bit  calm = 0;        // no idling in the last part of the run
    bit  hold_sink = 0;   // long receiver hold-off
    int  src_gap = 0;
    int  snk_gap = 0;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2, wr;
        for (int k = 0; k < 16; k++)
            w[k] = {blk[4*k], blk[4*k+1], blk[4*k+2], blk[4*k+3]};
        for (int k = 0; k < 8; k++)
            v[k] = hv[k];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wr = w[r];
            else
            begin
                s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                wr = s1 + w[(r-7)&15] + s0 + w[r&15];
                w[r&15] = wr;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + wr;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hv[k] += v[k];
    endfunction

    function automatic void restart();
        for (int k = 0; k < 8; k++)
            hv[k] = InitVector[k];
        fill = 0;
        total = '0;
    endfunction

    function automatic void absorb(input msg_item_t it);
        logic [63:0] bits;
        if (it.byte_present)
        begin
            blk[fill] = it.data_byte;
            fill++;
            total++;
            if (fill == BlockBytes)
            begin
                compress();
                fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        bits = {total, 3'b000};
        blk[fill] = PadMark;
        fill++;
        if (fill > LengthPos)
        begin
            while (fill < BlockBytes)
                blk[fill++] = 8'h00;
            compress();
            fill = 0;
        end
        while (fill < LengthPos)
            blk[fill++] = 8'h00;
        for (int k = 0; k < 8; k++)
            blk[LengthPos + k] = bits[63 - 8*k -: 8];
        compress();
        for (int k = 0; k < 8; k++)
            digest_queue.push_back('{hv[k], 3'(k), k == 7});
        restart();
    endfunction

    function automatic void add_message(input int len, input bit empty_end);
        for (int k = 0; k < len; k++)
            pending_items.push_back('{8'($urandom), 1'b1,
                                      (k == len - 1) && !empty_end});
        if (empty_end || len == 0)
            pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
    endfunction

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid          <= 1'b0;
            in_ch.data_byte      <= '0;
            in_ch.byte_present   <= 1'b0;
            in_ch.end_of_message <= 1'b0;
            src_gap              <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                absorb('{in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message});
            if (src_gap > 0)
            begin
                src_gap     <= src_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_ch.valid          <= 1'b1;
                {in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message}
                                     <= pending_items.pop_front();
                if (!calm && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 5);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h", out_ch.digest_word);
                end
                else
                begin
                    digest_res_t want;
                    want = digest_queue.pop_front();
                    if (want !== {out_ch.digest_word, out_ch.word_number, out_ch.final_word})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     want.digest_word, want.word_number, want.final_word,
                                     out_ch.digest_word, out_ch.word_number,
                                     out_ch.final_word);
                    end
                end
            end
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (snk_gap > 0)
            begin
                snk_gap      <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    snk_gap <= $urandom_range(1, 5);
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || digest_queue.size() > 0)
            @(posedge clk);
    endtask

    // long receiver hold-off while the sender keeps offering bytes
    initial
    begin
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
    end

    initial
    begin
        int n;
        restart();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, single bytes at both extremes,
        // 55/56 and 64 byte boundaries, byte and end together, idle item
        add_message(0, 1'b1);
        pending_items.push_back('{8'h00, 1'b1, 1'b1});
        pending_items.push_back('{8'hff, 1'b1, 1'b0});
        pending_items.push_back('{8'h5a, 1'b0, 1'b0});
        pending_items.push_back('{8'h00, 1'b0, 1'b1});
        add_message(3, 1'b0);
        add_message(55, 1'b0);
        add_message(56, 1'b1);
        add_message(64, 1'b0);
        wait_drained();
        repeat (150) @(posedge clk);

        // random messages, some ending with a bare end item
        n = 0;
        while (n < 16)
        begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 130)
                                              : $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
            add_message(len, $urandom_range(0, 3) == 0);
            n += len + 1;
        end
        // pause mid-run until all digests are out
        wait_drained();
        calm = 1'b1;
        add_message(70, 1'b0);
        wait_drained();
        repeat (150) @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
